>>> rtl/ilp_pkg.sv
// Shared types and constants for the intra 4x4 luma predictor.
`default_nettype none
package ilp_pkg;

    localparam int unsigned SlotCount   = 12;
    localparam int unsigned TopBase     = 4;
    localparam logic [12:0] WidthReset  = 13'd1920;

    typedef enum logic [1:0] {
        MODE_VERT = 2'd0,
        MODE_HORZ = 2'd1,
        MODE_DDL  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_PREDICT = 1'b1
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic       load;
        logic       capture;
        logic       emit;
        logic [3:0] pix;
    } t_ctrl_cmd;

endpackage
`default_nettype wire

>>> rtl/ilp_ctrl.sv
// Controller: sequences one predict request over sixteen pixels.
`default_nettype none
module ilp_ctrl
    import ilp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire logic      i_action,
    output logic           busy,
    output t_ctrl_cmd      o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       accept;

    assign accept = start && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 4'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = 4'd0;
                if (accept && (i_action == ACT_PREDICT)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy          = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.emit    = 1'b0;
        o_cmd.pix     = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load    = accept && (i_action == ACT_LOAD);
                o_cmd.capture = accept && (i_action == ACT_PREDICT);
            end
            ST_RUN: begin
                busy       = 1'b1;
                o_cmd.emit = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/ilp_dp.sv
// Datapath: sample store, neighbor capture and per-pixel prediction.
`default_nettype none
module ilp_dp
    import ilp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctrl_cmd   i_cmd,
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_wdata,
    input  wire logic [3:0]  i_sample_slot,
    input  wire logic [7:0]  i_sample_value,
    input  wire logic [1:0]  i_mode,
    input  wire logic [11:0] i_block_x,
    input  wire logic [11:0] i_block_y,
    output logic             o_strobe,
    output logic [1:0]       o_pixel_col,
    output logic [1:0]       o_pixel_row,
    output logic [7:0]       o_pixel_value,
    output logic             o_last
);

    logic [7:0]  r_store [SlotCount];
    logic [12:0] r_frame_width;
    logic [7:0]  r_left [4];
    logic [7:0]  r_top [8];
    t_mode       r_mode;
    logic        r_strobe;

    logic        left_ok, top_ok, right_ok;
    logic [1:0]  row, col;
    logic [2:0]  dsum;
    logic [7:0]  ta, tb, tc;
    logic [9:0]  acc;
    logic [7:0]  n_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_sample_slot < 4'(SlotCount))) begin
            r_store[i_sample_slot] <= i_sample_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= WidthReset;
        end else if (i_cfg_we) begin
            r_frame_width <= i_cfg_wdata;
        end
    end

    assign left_ok  = (i_block_x[11:2] != 10'd0);
    assign top_ok   = (i_block_y[11:2] != 10'd0);
    assign right_ok = (({1'b0, i_block_x} + 13'd8) <= r_frame_width);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= t_mode'(i_mode);
            for (int i = 0; i < 4; i++) begin
                r_left[i] <= left_ok ? r_store[i] : 8'd0;
                r_top[i]  <= top_ok ? r_store[TopBase + i] : 8'd0;
                r_top[i + 4] <= !top_ok ? 8'd0 :
                                right_ok ? r_store[TopBase + 4 + i] : r_store[TopBase + 3];
            end
        end
    end

    assign row  = i_cmd.pix[3:2];
    assign col  = i_cmd.pix[1:0];
    assign dsum = {1'b0, row} + {1'b0, col};

    always_comb begin
        ta = r_top[7];
        tb = r_top[7];
        tc = r_top[7];
        case (dsum)
            3'd0: begin ta = r_top[0]; tb = r_top[1]; tc = r_top[2]; end
            3'd1: begin ta = r_top[1]; tb = r_top[2]; tc = r_top[3]; end
            3'd2: begin ta = r_top[2]; tb = r_top[3]; tc = r_top[4]; end
            3'd3: begin ta = r_top[3]; tb = r_top[4]; tc = r_top[5]; end
            3'd4: begin ta = r_top[4]; tb = r_top[5]; tc = r_top[6]; end
            3'd5: begin ta = r_top[5]; tb = r_top[6]; tc = r_top[7]; end
            3'd6: begin ta = r_top[6]; tb = r_top[7]; tc = r_top[7]; end
            default: begin ta = r_top[7]; tb = r_top[7]; tc = r_top[7]; end
        endcase
    end

    assign acc = {2'b00, ta} + {1'b0, tb, 1'b0} + {2'b00, tc} + 10'd2;

    always_comb begin
        unique case (r_mode)
            MODE_VERT: n_value = r_top[{1'b0, col}];
            MODE_HORZ: n_value = r_left[row];
            MODE_DDL:  n_value = acc[9:2];
            MODE_NONE: n_value = 8'd0;
            default:   n_value = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_pixel_col   <= col;
            o_pixel_row   <= row;
            o_pixel_value <= n_value;
            o_last        <= (i_cmd.pix == 4'd15);
        end
    end

    assign o_strobe = r_strobe;

endmodule
`default_nettype wire

>>> rtl/intra4x4_luma_predictor.sv
// Top level: intra 4x4 luma predictor (vertical, horizontal, diagonal down-left).
// Load request: busy stays low, no result.
// Predict request: busy while the controller emits its pixels; pixels appear one per cycle in
// raster order, with o_last marking the last pixel.
// A new request is accepted only while idle, so a predict finishes before the next is taken.
// Synchronous active-low reset idles the controller and sets frame width to 1920.
`default_nettype none
module intra4x4_luma_predictor
    import ilp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_wdata,
    input  wire logic        i_action,
    input  wire logic [3:0]  i_sample_slot,
    input  wire logic [7:0]  i_sample_value,
    input  wire logic [1:0]  i_mode,
    input  wire logic [11:0] i_block_x,
    input  wire logic [11:0] i_block_y,
    output logic             o_strobe,
    output logic [1:0]       o_pixel_col,
    output logic [1:0]       o_pixel_row,
    output logic [7:0]       o_pixel_value,
    output logic             o_last
);

    t_ctrl_cmd cmd;

    ilp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    ilp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample_slot  (i_sample_slot),
        .i_sample_value (i_sample_value),
        .i_mode         (i_mode),
        .i_block_x      (i_block_x),
        .i_block_y      (i_block_y),
        .o_strobe       (o_strobe),
        .o_pixel_col    (o_pixel_col),
        .o_pixel_row    (o_pixel_row),
        .o_pixel_value  (o_pixel_value),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire
